// ----- src/qas_pkg.sv -----
package qas_pkg;

    localparam int FRAC = 16;

    localparam logic [1:0] KIND_UPDATE  = 2'd0;
    localparam logic [1:0] KIND_PREDICT = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [2:0] REG_RATE_X = 3'd0;
    localparam logic [2:0] REG_RATE_Y = 3'd1;
    localparam logic [2:0] REG_RATE_Z = 3'd2;
    localparam logic [2:0] REG_INIT_W = 3'd3;
    localparam logic [2:0] REG_INIT_X = 3'd4;
    localparam logic [2:0] REG_INIT_Y = 3'd5;
    localparam logic [2:0] REG_INIT_Z = 3'd6;
    localparam logic [2:0] REG_SPARE  = 3'd7;

    localparam logic [4:0] OP_Q0 = 5'd0;
    localparam logic [4:0] OP_Q1 = 5'd1;
    localparam logic [4:0] OP_Q2 = 5'd2;
    localparam logic [4:0] OP_Q3 = 5'd3;
    localparam logic [4:0] OP_H0 = 5'd4;
    localparam logic [4:0] OP_H1 = 5'd5;
    localparam logic [4:0] OP_H2 = 5'd6;
    localparam logic [4:0] OP_N0 = 5'd7;
    localparam logic [4:0] OP_N1 = 5'd8;
    localparam logic [4:0] OP_N2 = 5'd9;
    localparam logic [4:0] OP_N3 = 5'd10;
    localparam logic [4:0] OP_A0 = 5'd11;
    localparam logic [4:0] OP_A1 = 5'd12;
    localparam logic [4:0] OP_A2 = 5'd13;
    localparam logic [4:0] OP_A3 = 5'd14;
    localparam logic [4:0] OP_D0 = 5'd15;
    localparam logic [4:0] OP_D1 = 5'd16;
    localparam logic [4:0] OP_D2 = 5'd17;
    localparam logic [4:0] OP_D3 = 5'd18;
    localparam logic [4:0] OP_R0 = 5'd19;
    localparam logic [4:0] OP_R1 = 5'd20;
    localparam logic [4:0] OP_R2 = 5'd21;
    localparam logic [4:0] OP_DT = 5'd22;

    localparam logic [3:0] WR_NONE  = 4'd0;
    localparam logic [3:0] WR_H     = 4'd1;
    localparam logic [3:0] WR_N     = 4'd2;
    localparam logic [3:0] WR_SQRT  = 4'd3;
    localparam logic [3:0] WR_DIVN  = 4'd4;
    localparam logic [3:0] WR_A     = 4'd5;
    localparam logic [3:0] WR_ACOPY = 4'd6;
    localparam logic [3:0] WR_TIME  = 4'd7;
    localparam logic [3:0] WR_DIVE  = 4'd8;
    localparam logic [3:0] WR_EST   = 4'd9;
    localparam logic [3:0] WR_RST   = 4'd10;
    localparam logic [3:0] WR_OUT   = 4'd11;

    typedef struct packed {
        logic       load;
        logic       mac;
        logic       clr;
        logic       neg;
        logic [4:0] a_sel;
        logic [4:0] b_sel;
        logic [3:0] wr;
        logic [1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       dt_zero;
        logic       root_zero;
        logic       sqrt_done;
        logic       div_done;
        logic       out_free;
    } stat_t;

    function automatic logic signed [61:0] rnd_shr(input logic signed [61:0] v,
                                                   input int s);
        logic [61:0] mag;
        mag = v[61] ? 62'(-v) : 62'(v);
        mag = (mag + (62'(1) << (s - 1))) >> s;
        return v[61] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [17:0] clamp_q(input logic signed [23:0] v);
        if (v > 24'sd65536)
            return 18'sd65536;
        else if (v < -24'sd65536)
            return -18'sd65536;
        else
            return v[17:0];
    endfunction

endpackage

// ----- src/qas_sqrt.sv -----
module qas_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [59:0] radicand,
    output logic [29:0] root,
    output logic        done
);

    logic [59:0] rad_reg;
    logic [33:0] rem_reg;
    logic [29:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] shifted;
    logic [33:0] trial;

    assign shifted = {rem_reg[31:0], rad_reg[59:58]};
    assign trial   = {2'b00, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd29;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[57:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_reg  <= shifted - trial;
                root_reg <= {root_reg[28:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted;
                root_reg <= {root_reg[28:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

// ----- src/qas_div.sv -----
module qas_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [29:0] den,
    output logic [23:0] quot,
    output logic        done
);

    logic [30:0] rem_reg;
    logic [23:0] low_reg;
    logic [29:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [30:0] trial;

    assign trial = {rem_reg[29:0], low_reg[23]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd23;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {7'd0, num[47:24]};
            low_reg <= num[23:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                low_reg <= {low_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                low_reg <= {low_reg[22:0], 1'b0};
            end
        end
    end

    assign quot = low_reg;
    assign done = done_reg;

endmodule

// ----- src/qas_ctrl.sv -----
module qas_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qas_pkg::stat_t stat,
    output qas_pkg::cmd_t  cmd
);

    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_HX   = 6'd1;
    localparam logic [5:0] S_HY   = 6'd2;
    localparam logic [5:0] S_HZ   = 6'd3;
    localparam logic [5:0] S_N0A  = 6'd4;
    localparam logic [5:0] S_N0B  = 6'd5;
    localparam logic [5:0] S_N0C  = 6'd6;
    localparam logic [5:0] S_N1A  = 6'd7;
    localparam logic [5:0] S_N1B  = 6'd8;
    localparam logic [5:0] S_N1C  = 6'd9;
    localparam logic [5:0] S_N2A  = 6'd10;
    localparam logic [5:0] S_N2B  = 6'd11;
    localparam logic [5:0] S_N2C  = 6'd12;
    localparam logic [5:0] S_N3A  = 6'd13;
    localparam logic [5:0] S_N3B  = 6'd14;
    localparam logic [5:0] S_N3C  = 6'd15;
    localparam logic [5:0] S_SQ0  = 6'd16;
    localparam logic [5:0] S_SQ1  = 6'd17;
    localparam logic [5:0] S_SQ2  = 6'd18;
    localparam logic [5:0] S_SQ3  = 6'd19;
    localparam logic [5:0] S_SQS  = 6'd20;
    localparam logic [5:0] S_SQW  = 6'd21;
    localparam logic [5:0] S_DVS  = 6'd22;
    localparam logic [5:0] S_DVW  = 6'd23;
    localparam logic [5:0] S_ACPY = 6'd24;
    localparam logic [5:0] S_TIME = 6'd25;
    localparam logic [5:0] S_E0A  = 6'd26;
    localparam logic [5:0] S_E0B  = 6'd27;
    localparam logic [5:0] S_E0C  = 6'd28;
    localparam logic [5:0] S_E0D  = 6'd29;
    localparam logic [5:0] S_E1A  = 6'd30;
    localparam logic [5:0] S_E1B  = 6'd31;
    localparam logic [5:0] S_E1C  = 6'd32;
    localparam logic [5:0] S_E1D  = 6'd33;
    localparam logic [5:0] S_E2A  = 6'd34;
    localparam logic [5:0] S_E2B  = 6'd35;
    localparam logic [5:0] S_E2C  = 6'd36;
    localparam logic [5:0] S_E2D  = 6'd37;
    localparam logic [5:0] S_ES   = 6'd38;
    localparam logic [5:0] S_EW   = 6'd39;
    localparam logic [5:0] S_RST  = 6'd40;
    localparam logic [5:0] S_FIN  = 6'd41;

    logic [5:0] state_reg;
    logic [5:0] state_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_HX;
                end
            end
            S_HX:
            begin
                if (stat.kind == qas_pkg::KIND_RESTART)
                    state_next = S_RST;
                else if (stat.kind == qas_pkg::KIND_UPDATE ||
                         stat.kind == qas_pkg::KIND_PREDICT)
                begin
                    cmd.mac = 1'b1; cmd.clr = 1'b1;
                    cmd.a_sel = qas_pkg::OP_R0; cmd.b_sel = qas_pkg::OP_DT;
                    state_next = S_HY;
                end
                else
                    state_next = S_FIN;
            end
            S_HY:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = qas_pkg::OP_R1; cmd.b_sel = qas_pkg::OP_DT;
                cmd.wr = qas_pkg::WR_H; cmd.idx = 2'd0;
                state_next = S_HZ;
            end
            S_HZ:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = qas_pkg::OP_R2; cmd.b_sel = qas_pkg::OP_DT;
                cmd.wr = qas_pkg::WR_H; cmd.idx = 2'd1;
                state_next = S_N0A;
            end
            S_N0A:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q1; cmd.b_sel = qas_pkg::OP_H0;
                cmd.wr = qas_pkg::WR_H; cmd.idx = 2'd2;
                state_next = S_N0B;
            end
            S_N0B:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q2; cmd.b_sel = qas_pkg::OP_H1;
                state_next = S_N0C;
            end
            S_N0C:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q3; cmd.b_sel = qas_pkg::OP_H2;
                state_next = S_N1A;
            end
            S_N1A:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q0; cmd.b_sel = qas_pkg::OP_H0;
                cmd.wr = qas_pkg::WR_N; cmd.idx = 2'd0;
                state_next = S_N1B;
            end
            S_N1B:
            begin
                cmd.mac = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q2; cmd.b_sel = qas_pkg::OP_H2;
                state_next = S_N1C;
            end
            S_N1C:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q3; cmd.b_sel = qas_pkg::OP_H1;
                state_next = S_N2A;
            end
            S_N2A:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q0; cmd.b_sel = qas_pkg::OP_H1;
                cmd.wr = qas_pkg::WR_N; cmd.idx = 2'd1;
                state_next = S_N2B;
            end
            S_N2B:
            begin
                cmd.mac = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q3; cmd.b_sel = qas_pkg::OP_H0;
                state_next = S_N2C;
            end
            S_N2C:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q1; cmd.b_sel = qas_pkg::OP_H2;
                state_next = S_N3A;
            end
            S_N3A:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q0; cmd.b_sel = qas_pkg::OP_H2;
                cmd.wr = qas_pkg::WR_N; cmd.idx = 2'd2;
                state_next = S_N3B;
            end
            S_N3B:
            begin
                cmd.mac = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q1; cmd.b_sel = qas_pkg::OP_H1;
                state_next = S_N3C;
            end
            S_N3C:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_Q2; cmd.b_sel = qas_pkg::OP_H0;
                state_next = S_SQ0;
            end
            S_SQ0:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = qas_pkg::OP_N0; cmd.b_sel = qas_pkg::OP_N0;
                cmd.wr = qas_pkg::WR_N; cmd.idx = 2'd3;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                cmd.mac = 1'b1;
                cmd.a_sel = qas_pkg::OP_N1; cmd.b_sel = qas_pkg::OP_N1;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                cmd.mac = 1'b1;
                cmd.a_sel = qas_pkg::OP_N2; cmd.b_sel = qas_pkg::OP_N2;
                state_next = S_SQ3;
            end
            S_SQ3:
            begin
                cmd.mac = 1'b1;
                cmd.a_sel = qas_pkg::OP_N3; cmd.b_sel = qas_pkg::OP_N3;
                state_next = S_SQS;
            end
            S_SQS:
            begin
                cmd.wr = qas_pkg::WR_SQRT;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                if (stat.sqrt_done)
                begin
                    cnt_next = 2'd0;
                    state_next = stat.root_zero ? S_ACPY : S_DVS;
                end
            end
            S_DVS:
            begin
                cmd.wr = qas_pkg::WR_DIVN; cmd.idx = cnt_reg;
                state_next = S_DVW;
            end
            S_DVW:
            begin
                if (stat.div_done)
                begin
                    cmd.wr = qas_pkg::WR_A; cmd.idx = cnt_reg;
                    cnt_next = cnt_reg + 2'd1;
                    state_next = (cnt_reg == 2'd3) ? S_TIME : S_DVS;
                end
            end
            S_ACPY:
            begin
                cmd.wr = qas_pkg::WR_ACOPY;
                state_next = S_TIME;
            end
            S_TIME:
            begin
                cmd.wr = qas_pkg::WR_TIME;
                cnt_next = 2'd0;
                state_next = stat.dt_zero ? S_FIN : S_E0A;
            end
            S_E0A:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = qas_pkg::OP_A0; cmd.b_sel = qas_pkg::OP_D1;
                state_next = S_E0B;
            end
            S_E0B:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_D0; cmd.b_sel = qas_pkg::OP_A1;
                state_next = S_E0C;
            end
            S_E0C:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_A2; cmd.b_sel = qas_pkg::OP_D3;
                state_next = S_E0D;
            end
            S_E0D:
            begin
                cmd.mac = 1'b1;
                cmd.a_sel = qas_pkg::OP_A3; cmd.b_sel = qas_pkg::OP_D2;
                state_next = S_ES;
            end
            S_E1A:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = qas_pkg::OP_A0; cmd.b_sel = qas_pkg::OP_D2;
                state_next = S_E1B;
            end
            S_E1B:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_D0; cmd.b_sel = qas_pkg::OP_A2;
                state_next = S_E1C;
            end
            S_E1C:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_A3; cmd.b_sel = qas_pkg::OP_D1;
                state_next = S_E1D;
            end
            S_E1D:
            begin
                cmd.mac = 1'b1;
                cmd.a_sel = qas_pkg::OP_A1; cmd.b_sel = qas_pkg::OP_D3;
                state_next = S_ES;
            end
            S_E2A:
            begin
                cmd.mac = 1'b1; cmd.clr = 1'b1;
                cmd.a_sel = qas_pkg::OP_A0; cmd.b_sel = qas_pkg::OP_D3;
                state_next = S_E2B;
            end
            S_E2B:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_D0; cmd.b_sel = qas_pkg::OP_A3;
                state_next = S_E2C;
            end
            S_E2C:
            begin
                cmd.mac = 1'b1; cmd.neg = 1'b1;
                cmd.a_sel = qas_pkg::OP_A1; cmd.b_sel = qas_pkg::OP_D2;
                state_next = S_E2D;
            end
            S_E2D:
            begin
                cmd.mac = 1'b1;
                cmd.a_sel = qas_pkg::OP_A2; cmd.b_sel = qas_pkg::OP_D1;
                state_next = S_ES;
            end
            S_ES:
            begin
                cmd.wr = qas_pkg::WR_DIVE; cmd.idx = cnt_reg;
                state_next = S_EW;
            end
            S_EW:
            begin
                if (stat.div_done)
                begin
                    cmd.wr = qas_pkg::WR_EST; cmd.idx = cnt_reg;
                    cnt_next = cnt_reg + 2'd1;
                    case (cnt_reg)
                        2'd0:    state_next = S_E1A;
                        2'd1:    state_next = S_E2A;
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_RST:
            begin
                cmd.wr = qas_pkg::WR_RST;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.wr = qas_pkg::WR_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- src/qas_dp.sv -----
module qas_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  qas_pkg::cmd_t       cmd,
    output qas_pkg::stat_t      stat,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic [1:0]          kind,
    input  logic [15:0]         step_time,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [17:0]  orient_w,
    output logic signed [17:0]  orient_x,
    output logic signed [17:0]  orient_y,
    output logic signed [17:0]  orient_z,
    output logic [31:0]         elapsed,
    output logic signed [23:0]  est_rate_x,
    output logic signed [23:0]  est_rate_y,
    output logic signed [23:0]  est_rate_z,
    output logic                zero_step
);

    logic signed [23:0] rate_reg [3];
    logic signed [17:0] init_reg [4];
    logic signed [17:0] q_reg [4];
    logic [31:0]        time_reg;
    logic signed [23:0] h_reg [3];
    logic signed [29:0] n_reg [4];
    logic signed [17:0] a_reg [4];
    logic signed [18:0] d_val [4];
    logic signed [23:0] est_reg [3];
    logic               zf_reg;
    logic [1:0]         kind_reg;
    logic [15:0]        dt_reg;
    logic signed [61:0] acc_reg;
    logic signed [61:0] acc_next;
    logic               negv_reg;
    logic               ovf_reg;
    logic               out_valid_reg;
    logic signed [17:0] ow_reg [4];
    logic [31:0]        oel_reg;
    logic signed [23:0] oest_reg [3];
    logic               ozf_reg;

    logic signed [29:0] opa;
    logic signed [29:0] opb;
    logic signed [59:0] prod;
    logic signed [59:0] term;
    logic [29:0]        root;
    logic               sqrt_done;
    logic [47:0]        div_num;
    logic [29:0]        div_den;
    logic [23:0]        div_quot;
    logic               div_done;
    logic               div_start;
    logic [29:0]        n_mag;
    logic [61:0]        acc_mag;
    logic [61:0]        ef_full;
    logic [47:0]        est_num;
    logic [16:0]        a_clip;
    logic [23:0]        est_lim;
    logic [23:0]        est_tot;
    logic [32:0]        time_sum;

    function automatic logic signed [29:0] operand(input logic [4:0] sel,
        input logic signed [17:0] q0, input logic signed [17:0] q1,
        input logic signed [17:0] q2, input logic signed [17:0] q3);
        case (sel)
            qas_pkg::OP_Q0: return 30'(q0);
            qas_pkg::OP_Q1: return 30'(q1);
            qas_pkg::OP_Q2: return 30'(q2);
            qas_pkg::OP_Q3: return 30'(q3);
            default:        return '0;
        endcase
    endfunction

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            d_val[i] = 19'(a_reg[i]) - 19'(q_reg[i]);
    end

    always_comb
    begin
        case (cmd.a_sel)
            qas_pkg::OP_H0: opa = 30'(h_reg[0]);
            qas_pkg::OP_H1: opa = 30'(h_reg[1]);
            qas_pkg::OP_H2: opa = 30'(h_reg[2]);
            qas_pkg::OP_N0: opa = n_reg[0];
            qas_pkg::OP_N1: opa = n_reg[1];
            qas_pkg::OP_N2: opa = n_reg[2];
            qas_pkg::OP_N3: opa = n_reg[3];
            qas_pkg::OP_A0: opa = 30'(a_reg[0]);
            qas_pkg::OP_A1: opa = 30'(a_reg[1]);
            qas_pkg::OP_A2: opa = 30'(a_reg[2]);
            qas_pkg::OP_A3: opa = 30'(a_reg[3]);
            qas_pkg::OP_D0: opa = 30'(d_val[0]);
            qas_pkg::OP_D1: opa = 30'(d_val[1]);
            qas_pkg::OP_D2: opa = 30'(d_val[2]);
            qas_pkg::OP_D3: opa = 30'(d_val[3]);
            qas_pkg::OP_R0: opa = 30'(rate_reg[0]);
            qas_pkg::OP_R1: opa = 30'(rate_reg[1]);
            qas_pkg::OP_R2: opa = 30'(rate_reg[2]);
            qas_pkg::OP_DT: opa = $signed({14'd0, dt_reg});
            default:        opa = operand(cmd.a_sel, q_reg[0], q_reg[1], q_reg[2], q_reg[3]);
        endcase
        case (cmd.b_sel)
            qas_pkg::OP_H0: opb = 30'(h_reg[0]);
            qas_pkg::OP_H1: opb = 30'(h_reg[1]);
            qas_pkg::OP_H2: opb = 30'(h_reg[2]);
            qas_pkg::OP_N0: opb = n_reg[0];
            qas_pkg::OP_N1: opb = n_reg[1];
            qas_pkg::OP_N2: opb = n_reg[2];
            qas_pkg::OP_N3: opb = n_reg[3];
            qas_pkg::OP_A0: opb = 30'(a_reg[0]);
            qas_pkg::OP_A1: opb = 30'(a_reg[1]);
            qas_pkg::OP_A2: opb = 30'(a_reg[2]);
            qas_pkg::OP_A3: opb = 30'(a_reg[3]);
            qas_pkg::OP_D0: opb = 30'(d_val[0]);
            qas_pkg::OP_D1: opb = 30'(d_val[1]);
            qas_pkg::OP_D2: opb = 30'(d_val[2]);
            qas_pkg::OP_D3: opb = 30'(d_val[3]);
            qas_pkg::OP_R0: opb = 30'(rate_reg[0]);
            qas_pkg::OP_R1: opb = 30'(rate_reg[1]);
            qas_pkg::OP_R2: opb = 30'(rate_reg[2]);
            qas_pkg::OP_DT: opb = $signed({14'd0, dt_reg});
            default:        opb = operand(cmd.b_sel, q_reg[0], q_reg[1], q_reg[2], q_reg[3]);
        endcase
    end

    assign prod     = opa * opb;
    assign term     = cmd.neg ? -prod : prod;
    assign acc_next = (cmd.clr ? 62'sd0 : acc_reg) + 62'(term);

    assign n_mag   = n_reg[cmd.idx][29] ? 30'(-n_reg[cmd.idx]) : 30'(n_reg[cmd.idx]);
    assign acc_mag = acc_reg[61] ? 62'(-acc_reg) : 62'(acc_reg);
    assign ef_full = (acc_mag + 62'(1 << (qas_pkg::FRAC - 1))) >> qas_pkg::FRAC;
    assign est_num = {ef_full[30:0], 17'd0} + 48'(dt_reg >> 1);

    assign div_start = (cmd.wr == qas_pkg::WR_DIVN) || (cmd.wr == qas_pkg::WR_DIVE);
    assign div_num   = (cmd.wr == qas_pkg::WR_DIVN) ?
                       ({2'd0, n_mag, 16'd0} + 48'(root >> 1)) : est_num;
    assign div_den   = (cmd.wr == qas_pkg::WR_DIVN) ? root : {14'd0, dt_reg};

    assign a_clip  = (div_quot > 24'd65536) ? 17'd65536 : div_quot[16:0];
    assign est_lim = negv_reg ? 24'd8388608 : 24'd8388607;
    assign est_tot = (ovf_reg || div_quot > est_lim) ? est_lim : div_quot;
    assign time_sum = {1'b0, time_reg} + {17'd0, dt_reg};

    qas_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.wr == qas_pkg::WR_SQRT),
        .radicand (acc_reg[59:0]),
        .root     (root),
        .done     (sqrt_done)
    );

    qas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                rate_reg[i] <= '0;
            init_reg[0] <= 18'sd65536;
            init_reg[1] <= '0;
            init_reg[2] <= '0;
            init_reg[3] <= '0;
            q_reg[0] <= 18'sd65536;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
            time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    qas_pkg::REG_RATE_X: rate_reg[0] <= cfg_data;
                    qas_pkg::REG_RATE_Y: rate_reg[1] <= cfg_data;
                    qas_pkg::REG_RATE_Z: rate_reg[2] <= cfg_data;
                    qas_pkg::REG_INIT_W: init_reg[0] <= cfg_data[17:0];
                    qas_pkg::REG_INIT_X: init_reg[1] <= cfg_data[17:0];
                    qas_pkg::REG_INIT_Y: init_reg[2] <= cfg_data[17:0];
                    qas_pkg::REG_INIT_Z: init_reg[3] <= cfg_data[17:0];
                    default: ;
                endcase
            end
            if (cmd.wr == qas_pkg::WR_RST)
            begin
                for (int i = 0; i < 4; i++)
                    q_reg[i] <= qas_pkg::clamp_q(24'(init_reg[i]));
                time_reg <= '0;
            end
            if (cmd.wr == qas_pkg::WR_TIME && kind_reg == qas_pkg::KIND_UPDATE)
                time_reg <= time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
            if (cmd.wr == qas_pkg::WR_OUT &&
                (kind_reg == qas_pkg::KIND_UPDATE || kind_reg == qas_pkg::KIND_PREDICT))
            begin
                for (int i = 0; i < 4; i++)
                    q_reg[i] <= a_reg[i];
            end
            if (cmd.wr == qas_pkg::WR_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac)
            acc_reg <= acc_next;
        if (cmd.load)
        begin
            kind_reg <= kind;
            dt_reg   <= step_time;
            zf_reg   <= (kind == qas_pkg::KIND_UPDATE || kind == qas_pkg::KIND_PREDICT) &&
                        (step_time == 16'd0);
            for (int i = 0; i < 3; i++)
                est_reg[i] <= '0;
        end
        case (cmd.wr)
            qas_pkg::WR_H:
                h_reg[cmd.idx] <= 24'(qas_pkg::rnd_shr(acc_reg, qas_pkg::FRAC + 1));
            qas_pkg::WR_N:
                n_reg[cmd.idx] <= 30'(q_reg[cmd.idx]) +
                                  30'(qas_pkg::rnd_shr(acc_reg, qas_pkg::FRAC));
            qas_pkg::WR_A:
                a_reg[cmd.idx] <= n_reg[cmd.idx][29] ? -$signed({1'b0, a_clip}) :
                                  $signed({1'b0, a_clip});
            qas_pkg::WR_ACOPY:
                for (int i = 0; i < 4; i++)
                    a_reg[i] <= q_reg[i];
            qas_pkg::WR_DIVE:
            begin
                negv_reg <= acc_reg[61];
                ovf_reg  <= est_num >= {dt_reg, 32'd0} >> 8;
            end
            qas_pkg::WR_EST:
                est_reg[cmd.idx] <= negv_reg ? -$signed(est_tot) : $signed(est_tot);
            qas_pkg::WR_OUT:
            begin
                for (int i = 0; i < 4; i++)
                    ow_reg[i] <= (kind_reg == qas_pkg::KIND_UPDATE ||
                                  kind_reg == qas_pkg::KIND_PREDICT) ? a_reg[i] : q_reg[i];
                oel_reg <= (cmd.wr == qas_pkg::WR_OUT && kind_reg == qas_pkg::KIND_RESTART)
                           ? 32'd0 : time_reg;
                for (int i = 0; i < 3; i++)
                    oest_reg[i] <= est_reg[i];
                ozf_reg <= zf_reg;
            end
            default: ;
        endcase
    end

    assign stat.kind      = kind_reg;
    assign stat.dt_zero   = (dt_reg == 16'd0);
    assign stat.root_zero = (root == 30'd0);
    assign stat.sqrt_done = sqrt_done;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign orient_w   = ow_reg[0];
    assign orient_x   = ow_reg[1];
    assign orient_y   = ow_reg[2];
    assign orient_z   = ow_reg[3];
    assign elapsed    = oel_reg;
    assign est_rate_x = oest_reg[0];
    assign est_rate_y = oest_reg[1];
    assign est_rate_z = oest_reg[2];
    assign zero_step  = ozf_reg;

endmodule

// ----- src/quaternion_attitude_step.sv -----
// Channel   Handshake              Payload
// input     in_valid / in_ready    kind, step_time
// output    out_valid / out_ready  orient_w..z, elapsed, est_rate_x..z, zero_step
// config    cfg_write              cfg_index, cfg_data
//
// An update or predict transaction runs, between one input acceptance and the next,
// through 31 multiply-accumulate steps, a 30-step square root, four 24-step
// normalizing divides and three 24-step rate divides, all through one shared
// multiplier and one divider. A zero time step skips the rate products and divides;
// a zero norm replaces the normalizing divides by one copy.
// Restart and the unused kind skip all of the arithmetic.
// Reset restores the identity quaternion, zero time and the register defaults.
// A finished result waits in the output register while the next transaction is taken.
module quaternion_attitude_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [15:0]        step_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [17:0] orient_w,
    output logic signed [17:0] orient_x,
    output logic signed [17:0] orient_y,
    output logic signed [17:0] orient_z,
    output logic [31:0]        elapsed,
    output logic signed [23:0] est_rate_x,
    output logic signed [23:0] est_rate_y,
    output logic signed [23:0] est_rate_z,
    output logic               zero_step,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    qas_pkg::cmd_t  cmd;
    qas_pkg::stat_t stat;

    qas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qas_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .step_time  (step_time),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .orient_w   (orient_w),
        .orient_x   (orient_x),
        .orient_y   (orient_y),
        .orient_z   (orient_z),
        .elapsed    (elapsed),
        .est_rate_x (est_rate_x),
        .est_rate_y (est_rate_y),
        .est_rate_z (est_rate_z),
        .zero_step  (zero_step)
    );

endmodule
